[rtl/core/lpse_pkg.sv]
`timescale 1ns / 1ps
package lpse_pkg;

  // widths of the item fields
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned EXT_W   = 16;

  typedef enum logic [1:0] {
    OP_PARSE     = 2'd0,
    OP_WR_ACTION = 2'd1,
    OP_WR_PROD   = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_AMBIG  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_SHIFT    = 3'd0,
    ST_REDUCE   = 3'd1,
    ST_ERROR    = 3'd2,
    ST_AMBIG    = 3'd3,
    ST_WRITTEN  = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_TOP,
    BS_ACT,
    BS_FB,
    BS_PROD,
    BS_GTOP,
    BS_GACT
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] token;
    logic [SYM_W-1:0] state_sel;
    kind_t            action_kind;
    logic [SYM_W-1:0] action_value;
    logic [SYM_W-1:0] production_index;
    logic [LEN_W-1:0] body_length;
    logic [SYM_W-1:0] head_symbol;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [SYM_W-1:0] production_number;
    logic [SYM_W-1:0] accepted_symbol;
    logic [LEN_W-1:0] stack_depth;
  } out_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] value;
  } act_entry_t;

  typedef struct packed {
    logic [LEN_W-1:0] body_length;
    logic [SYM_W-1:0] head_symbol;
  } prod_entry_t;

  // handshake between front queue and back sequencer
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

endpackage

[rtl/core/lpse_front.sv]
`timescale 1ns / 1ps
module lpse_front
  import lpse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        hold,
  input  logic        pop,
  output queue_head_t head
);

  in_item_t    fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        do_pop;

  // accept while there is room and the table clear is done
  assign in_ready = (count_r != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = fifo_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |-> !in_ready)
    else $error("ready while queue full");
`endif

endmodule

[rtl/core/lpse_back.sv]
`timescale 1ns / 1ps
module lpse_back
  import lpse_pkg::*;
#(
  parameter int unsigned STATE_BITS       = 8,
  parameter int unsigned SYMBOL_BITS      = 8,
  parameter int unsigned STACK_DEPTH      = 64,
  parameter int unsigned PRODUCTION_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int unsigned AA_W  = STATE_BITS + SYMBOL_BITS;
  localparam int unsigned SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PA_W  = (PRODUCTION_COUNT > 1) ? $clog2(PRODUCTION_COUNT) : 1;
  localparam int unsigned CMP_W = (SP_W > LEN_W) ? SP_W : LEN_W;

  function automatic logic [AA_W-1:0] act_idx(input logic [SYM_W-1:0] st,
                                              input logic [SYM_W-1:0] sym);
    logic [EXT_W-1:0] se;
    logic [EXT_W-1:0] ye;
    se = EXT_W'(st);
    ye = EXT_W'(sym);
    return {se[STATE_BITS-1:0], ye[SYMBOL_BITS-1:0]};
  endfunction

  // memories
  act_entry_t  act_mem  [2**AA_W];
  prod_entry_t prod_mem [2**PA_W];
  logic [SYM_W-1:0] stack_mem [2**SA_W];

  act_entry_t       act_q;
  prod_entry_t      prod_q;
  logic [SYM_W-1:0] stack_q;

  logic             act_we, act_re;
  logic [AA_W-1:0]  act_addr;
  act_entry_t       act_wd;
  logic             prod_we, prod_re;
  logic [PA_W-1:0]  prod_addr;
  prod_entry_t      prod_wd;
  logic             stk_we, stk_re;
  logic [SA_W-1:0]  stk_waddr, stk_raddr;
  logic [SYM_W-1:0] stk_wd;

  // control and architectural state
  back_state_t      state_r, state_nxt;
  logic             clear_r, clear_nxt;
  logic [AA_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [SYM_W-1:0] acc_r, acc_nxt;
  logic [SYM_W-1:0] top_r, top_nxt;
  logic [SYM_W-1:0] pno_r, pno_nxt;
  logic [SYM_W-1:0] head_r, head_nxt;
  in_item_t         item_r, item_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             can_start;
  logic             finish;
  status_t          res_status;
  logic [SYM_W-1:0] res_pno;
  act_entry_t       entry;
  logic [SYM_W-1:0] top_now;
  logic [SP_W-1:0]  sp_m1;
  logic [SP_W-1:0]  sp_red;
  logic [SP_W-1:0]  sp_red_m1;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] sp_ext;
  logic             stack_full;

  assign clearing   = clear_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign can_start  = head.valid && !clear_r && (!out_valid_r || out_ready);
  assign top_now    = (sp_r == '0) ? '0 : stack_q;
  assign sp_m1      = sp_r - SP_W'(1);
  assign len_ext    = CMP_W'(prod_q.body_length);
  assign sp_ext     = CMP_W'(sp_r);
  assign sp_red     = SP_W'(sp_ext - len_ext);
  assign sp_red_m1  = sp_red - SP_W'(1);
  assign stack_full = (sp_r >= SP_W'(STACK_DEPTH));
  assign entry      = act_q;

  // sequencer: next state and memory controls
  always_comb begin
    state_nxt   = state_r;
    clear_nxt   = clear_r;
    clr_cnt_nxt = clr_cnt_r;
    sp_nxt      = sp_r;
    acc_nxt     = acc_r;
    top_nxt     = top_r;
    pno_nxt     = pno_r;
    head_nxt    = head_r;
    item_nxt    = item_r;
    pop         = 1'b0;
    finish      = 1'b0;
    res_status  = ST_ERROR;
    res_pno     = '0;
    act_we      = 1'b0;
    act_re      = 1'b0;
    act_addr    = '0;
    act_wd      = '0;
    prod_we     = 1'b0;
    prod_re     = 1'b0;
    prod_addr   = '0;
    prod_wd     = '0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = sp_r[SA_W-1:0];
    stk_raddr   = sp_m1[SA_W-1:0];
    stk_wd      = '0;

    if (clear_r) begin
      // sweep the action table to empty after reset
      act_we      = 1'b1;
      act_addr    = clr_cnt_r;
      clr_cnt_nxt = clr_cnt_r + AA_W'(1);
      if (clr_cnt_r == '1) begin
        clear_nxt = 1'b0;
      end
    end else begin
      case (state_r)
        BS_IDLE: begin
          if (can_start) begin
            pop      = 1'b1;
            item_nxt = head.item;
            case (head.item.op)
              OP_WR_ACTION: begin
                act_we       = 1'b1;
                act_addr     = act_idx(head.item.state_sel, head.item.token);
                act_wd.kind  = head.item.action_kind;
                act_wd.value = head.item.action_value;
                finish       = 1'b1;
                res_status   = ST_WRITTEN;
              end
              OP_WR_PROD: begin
                prod_we     = 32'(head.item.production_index) < PRODUCTION_COUNT;
                prod_addr   = PA_W'(32'(head.item.production_index));
                prod_wd.body_length = head.item.body_length;
                prod_wd.head_symbol = head.item.head_symbol;
                finish      = 1'b1;
                res_status  = ST_WRITTEN;
              end
              OP_CLEAR: begin
                sp_nxt     = '0;
                acc_nxt    = '0;
                finish     = 1'b1;
                res_status = ST_CLEARED;
              end
              default: begin
                // parse: read top of stack first
                acc_nxt   = '0;
                stk_re    = 1'b1;
                state_nxt = BS_TOP;
              end
            endcase
          end
        end
        BS_TOP: begin
          top_nxt   = top_now;
          act_re    = 1'b1;
          act_addr  = act_idx(top_now, item_r.token);
          state_nxt = BS_ACT;
        end
        BS_ACT, BS_FB: begin
          if (state_r == BS_ACT && entry.kind == KIND_EMPTY) begin
            // fall back to the null symbol
            act_re    = 1'b1;
            act_addr  = act_idx(top_r, '0);
            state_nxt = BS_FB;
          end else begin
            case (entry.kind)
              KIND_SHIFT: begin
                finish    = 1'b1;
                state_nxt = BS_IDLE;
                if (stack_full) begin
                  res_status = ST_OVERFLOW;
                end else begin
                  stk_we     = 1'b1;
                  stk_wd     = entry.value;
                  sp_nxt     = sp_r + SP_W'(1);
                  res_status = ST_SHIFT;
                end
              end
              KIND_REDUCE: begin
                if (32'(entry.value) >= PRODUCTION_COUNT) begin
                  finish     = 1'b1;
                  res_status = ST_ERROR;
                  state_nxt  = BS_IDLE;
                end else begin
                  prod_re   = 1'b1;
                  prod_addr = PA_W'(32'(entry.value));
                  pno_nxt   = entry.value;
                  state_nxt = BS_PROD;
                end
              end
              KIND_AMBIG: begin
                finish     = 1'b1;
                res_status = ST_AMBIG;
                state_nxt  = BS_IDLE;
              end
              default: begin
                finish     = 1'b1;
                res_status = ST_ERROR;
                state_nxt  = BS_IDLE;
              end
            endcase
          end
        end
        BS_PROD: begin
          if (len_ext > sp_ext) begin
            finish     = 1'b1;
            res_status = ST_ERROR;
            state_nxt  = BS_IDLE;
          end else begin
            sp_nxt  = sp_red;
            acc_nxt = (sp_red == '0) ? prod_q.head_symbol : '0;
            res_pno = pno_r;
            if (prod_q.head_symbol == '0) begin
              finish     = 1'b1;
              res_status = ST_REDUCE;
              state_nxt  = BS_IDLE;
            end else begin
              // uncovered state for the goto lookup
              stk_re    = 1'b1;
              stk_raddr = sp_red_m1[SA_W-1:0];
              head_nxt  = prod_q.head_symbol;
              state_nxt = BS_GTOP;
            end
          end
        end
        BS_GTOP: begin
          act_re    = 1'b1;
          act_addr  = act_idx(top_now, head_r);
          state_nxt = BS_GACT;
        end
        BS_GACT: begin
          finish     = 1'b1;
          res_pno    = pno_r;
          res_status = ST_REDUCE;
          state_nxt  = BS_IDLE;
          if (entry.kind != KIND_EMPTY) begin
            if (stack_full) begin
              res_status = ST_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              stk_wd = entry.value;
              sp_nxt = sp_r + SP_W'(1);
            end
          end
        end
        default: begin
          state_nxt = BS_IDLE;
        end
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (finish) begin
      out_valid_nxt             = 1'b1;
      out_nxt.status            = res_status;
      out_nxt.production_number = res_pno;
      out_nxt.accepted_symbol   = acc_nxt;
      out_nxt.stack_depth       = LEN_W'(sp_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      clear_r     <= 1'b1;
      clr_cnt_r   <= '0;
      sp_r        <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_r     <= clear_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    pno_r  <= pno_nxt;
    head_r <= head_nxt;
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  // action table, one port
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_addr] <= act_wd;
    end else if (act_re) begin
      act_q <= act_mem[act_addr];
    end
  end

  // production table
  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_addr] <= prod_wd;
    end
    if (prod_re) begin
      prod_q <= prod_mem[prod_addr];
    end
  end

  // state stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wd;
    end
    if (stk_re) begin
      stack_q <= stack_mem[stk_raddr];
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !clear_r && state_r == BS_IDLE)
    else $error("item taken while busy or clearing");
  a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !out_valid_r)
    else $error("result during table clear");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> !stack_full)
    else $error("push on full stack");
`endif

endmodule

[rtl/core/lalr_parse_step_engine_core.sv]
`timescale 1ns / 1ps
// LALR parse step engine
// in channel (in_valid/in_ready/in_data): one item per transfer: parse a token,
// write an action entry, write a production entry, or clear the stack.
// out channel (out_valid/out_ready/out_data): exactly one result per item,
// in order: status, reduced production, accepted head and stack depth.
// A two-entry queue sits in front of the sequencer, so in_ready stays high
// while the sequencer works or the receiver stalls, until the queue fills.
// The sequencer works on one item at a time: it takes no new item until it
// has finished the last. Writes and clear finish as the item is taken; a
// parse runs, as far as it needs, a chain of dependent synchronous reads of
// stack, action table, null-symbol fallback entry (only when the token's
// entry is empty), production table, then the uncovered stack entry and the
// goto entry.
// After reset the action table is swept to empty, one entry a cycle, over all
// 2**(STATE_BITS+SYMBOL_BITS) entries (65536 by default); in_ready is low
// during the sweep. A stalled receiver holds the result; the sequencer takes
// no new item until the result register can be loaded.
module lalr_parse_step_engine_core
  import lpse_pkg::*;
#(
  parameter int unsigned STATE_BITS       = 8,
  parameter int unsigned SYMBOL_BITS      = 8,
  parameter int unsigned STACK_DEPTH      = 64,
  parameter int unsigned PRODUCTION_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  queue_head_t q_head;
  logic        q_pop;
  logic        clearing;

  // front: input queue
  lpse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hold     (clearing),
    .pop      (q_pop),
    .head     (q_head)
  );

  // back: table lookups, stack and result register
  lpse_back #(
    .STATE_BITS       (STATE_BITS),
    .SYMBOL_BITS      (SYMBOL_BITS),
    .STACK_DEPTH      (STACK_DEPTH),
    .PRODUCTION_COUNT (PRODUCTION_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/lalr_parse_step_engine_core_test.sv]
`timescale 1ns / 1ps
module lalr_parse_step_engine_core_test;
  import lpse_pkg::*;

  localparam int unsigned ACT_SIZE   = 65536;
  localparam int unsigned STACK_MAX  = 64;
  localparam int unsigned PROD_SIZE  = 256;
  localparam int unsigned RAND_ITEMS = 930;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DIR_ROWS   = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // predictor state of the parser
  kind_t       pm_kind [ACT_SIZE];
  logic [7:0]  pm_val [ACT_SIZE];
  logic [6:0]  pm_len [PROD_SIZE];
  logic [7:0]  pm_head [PROD_SIZE];
  logic [7:0]  pm_stack [STACK_MAX];
  int unsigned pm_sp;
  logic [7:0]  pm_acc;

  out_item_t   pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;

  in_item_t    dir_item [DIR_ROWS];
  bit          dir_typed [DIR_ROWS];
  out_item_t   dir_result [DIR_ROWS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lalr_parse_step_engine_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic in_item_t mk(op_t op, int tok, int ssel, kind_t kd, int aval,
                                  int pidx, int blen, int head);
    in_item_t it;
    it.op               = op;
    it.token            = tok[7:0];
    it.state_sel        = ssel[7:0];
    it.action_kind      = kd;
    it.action_value     = aval[7:0];
    it.production_index = pidx[7:0];
    it.body_length      = blen[6:0];
    it.head_symbol      = head[7:0];
    return it;
  endfunction

  function automatic out_item_t res(status_t s, int depth);
    out_item_t r;
    r.status            = s;
    r.production_number = '0;
    r.accepted_symbol   = '0;
    r.stack_depth       = depth[6:0];
    return r;
  endfunction

  function automatic logic [7:0] top_state();
    return (pm_sp == 0) ? 8'd0 : pm_stack[pm_sp-1];
  endfunction

  function automatic bit push_state(logic [7:0] s);
    if (pm_sp >= STACK_MAX) return 1'b0;
    pm_stack[pm_sp] = s;
    pm_sp++;
    return 1'b1;
  endfunction

  // advance the parser by one item and return its result
  function automatic out_item_t parse_step(in_item_t it);
    out_item_t   r;
    logic [15:0] ix;
    logic [15:0] gx;
    logic [7:0]  p;
    logic [7:0]  h;
    r = '0;
    r.status = ST_ERROR;
    case (it.op)
      OP_WR_ACTION: begin
        ix = {it.state_sel, it.token};
        pm_kind[ix] = it.action_kind;
        pm_val[ix]  = it.action_value;
        r.status = ST_WRITTEN;
      end
      OP_WR_PROD: begin
        pm_len[it.production_index]  = it.body_length;
        pm_head[it.production_index] = it.head_symbol;
        r.status = ST_WRITTEN;
      end
      OP_CLEAR: begin
        pm_sp  = 0;
        pm_acc = '0;
        r.status = ST_CLEARED;
      end
      default: begin
        pm_acc = '0;
        ix = {top_state(), it.token};
        if (pm_kind[ix] == KIND_EMPTY) ix = {top_state(), 8'd0};
        case (pm_kind[ix])
          KIND_EMPTY: r.status = ST_ERROR;
          KIND_SHIFT: r.status = push_state(pm_val[ix]) ? ST_SHIFT : ST_OVERFLOW;
          KIND_REDUCE: begin
            p = pm_val[ix];
            if (pm_len[p] > pm_sp) begin
              r.status = ST_ERROR;
            end else begin
              h = pm_head[p];
              pm_sp -= pm_len[p];
              r.production_number = p;
              r.status = ST_REDUCE;
              if (pm_sp == 0) pm_acc = h;
              if (h != 0) begin
                gx = {top_state(), h};
                if (pm_kind[gx] != KIND_EMPTY && !push_state(pm_val[gx]))
                  r.status = ST_OVERFLOW;
              end
            end
          end
          default: r.status = ST_AMBIG;
        endcase
      end
    endcase
    r.accepted_symbol = pm_acc;
    r.stack_depth     = pm_sp[6:0];
    return r;
  endfunction

  // small grammar region so parses hit real entries most of the time
  function automatic in_item_t rand_item();
    int    sel;
    int    ssel;
    int    tok;
    int    kd;
    int    blen;
    kind_t k;
    sel  = $urandom_range(0, 99);
    ssel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    tok  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    kd   = $urandom_range(0, 99);
    k    = (kd < 45) ? KIND_SHIFT : (kd < 75) ? KIND_REDUCE :
           (kd < 87) ? KIND_EMPTY : KIND_AMBIG;
    blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
    if (sel < 55)
      return mk(OP_PARSE, tok, $urandom_range(0, 255), kind_t'($urandom_range(0, 3)),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 127),
                $urandom_range(0, 255));
    if (sel < 85)
      return mk(OP_WR_ACTION, tok, ssel, k,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15),
                $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 255));
    if (sel < 97)
      return mk(OP_WR_PROD, tok, ssel, k, $urandom_range(0, 255), $urandom_range(0, 255),
                blen, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 7));
    return mk(OP_CLEAR, tok, ssel, k, $urandom_range(0, 255), $urandom_range(0, 255),
              blen, $urandom_range(0, 255));
  endfunction

  // one transfer on the input channel, with an optional gap before it
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    r = parse_step(it);
    pending_results = {pending_results, (typed ? typed_res : r)};
  endtask

  // result channel stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status ||
            out_data.production_number !== e.production_number ||
            out_data.accepted_symbol !== e.accepted_symbol ||
            out_data.stack_depth !== e.stack_depth) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL lalr_parse_step_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < ACT_SIZE; i++) begin
      pm_kind[i] = KIND_EMPTY;
      pm_val[i]  = '0;
    end
    pm_sp  = 0;
    pm_acc = '0;

    // directed rows: typed result where obvious, predictor otherwise
    dir_item[0]  = mk(OP_PARSE, 0, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[1]  = mk(OP_PARSE, 255, 255, KIND_AMBIG, 255, 255, 127, 255);
    dir_item[2]  = mk(OP_CLEAR, 0, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[3]  = mk(OP_WR_ACTION, 1, 0, KIND_SHIFT, 8'h80, 0, 0, 0);
    dir_item[4]  = mk(OP_WR_ACTION, 0, 8'h80, KIND_REDUCE, 5, 0, 0, 0);
    dir_item[5]  = mk(OP_WR_PROD, 0, 0, KIND_EMPTY, 0, 5, 1, 8'h40);
    dir_item[6]  = mk(OP_WR_ACTION, 8'h40, 0, KIND_SHIFT, 8'hff, 0, 0, 0);
    dir_item[7]  = mk(OP_WR_PROD, 0, 0, KIND_EMPTY, 0, 255, 127, 255);
    dir_item[8]  = mk(OP_WR_ACTION, 255, 255, KIND_AMBIG, 255, 0, 0, 0);
    dir_item[9]  = mk(OP_PARSE, 1, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[10] = mk(OP_PARSE, 9, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[11] = mk(OP_PARSE, 255, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[12] = mk(OP_WR_ACTION, 2, 255, KIND_REDUCE, 255, 0, 0, 0);
    dir_item[13] = mk(OP_PARSE, 2, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[14] = mk(OP_WR_PROD, 0, 0, KIND_EMPTY, 0, 6, 0, 0);
    dir_item[15] = mk(OP_WR_ACTION, 3, 255, KIND_REDUCE, 6, 0, 0, 0);
    dir_item[16] = mk(OP_PARSE, 3, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[17] = mk(OP_WR_ACTION, 4, 255, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[18] = mk(OP_PARSE, 4, 0, KIND_EMPTY, 0, 0, 0, 0);
    dir_item[19] = mk(OP_CLEAR, 255, 255, KIND_AMBIG, 255, 255, 127, 255);
    for (i = 0; i < DIR_ROWS; i++) dir_typed[i] = 1'b0;
    dir_typed[0] = 1'b1;  dir_result[0] = res(ST_ERROR, 0);
    dir_typed[1] = 1'b1;  dir_result[1] = res(ST_ERROR, 0);
    dir_typed[2] = 1'b1;  dir_result[2] = res(ST_CLEARED, 0);
    dir_typed[3] = 1'b1;  dir_result[3] = res(ST_WRITTEN, 0);
    dir_typed[7] = 1'b1;  dir_result[7] = res(ST_WRITTEN, 0);
    dir_typed[19] = 1'b1; dir_result[19] = res(ST_CLEARED, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) send_item(dir_item[i], dir_typed[i], dir_result[i]);

    // every production gets written before random reduces can name it
    for (i = 0; i < PROD_SIZE; i++)
      send_item(mk(OP_WR_PROD, 0, 0, KIND_EMPTY, 0, i, $urandom_range(0, 3),
                   $urandom_range(0, 7)), 1'b0, '0);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) begin
        // hold off until every result is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_item(rand_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS lalr_parse_step_engine_core");
    end else begin
      $display("FAIL lalr_parse_step_engine_core");
    end
    $finish;
  end

endmodule
